// ===== design/iabst_pkg.sv =====
// Shared types and constants for the implicit-array binary search tree block.
`default_nettype none

package iabst_pkg;

    // Fixed widths of the stream fields.
    localparam int KEY_IN_W   = 16;
    localparam int STATUS_W   = 3;
    localparam int POS_W      = 13;
    localparam int PROBE_W    = 4;
    localparam int OUT_DATA_W = 24;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] STS_DUP    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOROOM = 3'd2;
    localparam logic [STATUS_W-1:0] STS_ZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_SEARCH = 3'd4;

    // Request modes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // write one zero during the clearing pass
        logic accept;    // take a new request
        logic walk;      // evaluate one tree level
        logic load_out;  // move the finished result to the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // clearing pass is at its last slot
        logic in_zero;    // offered request is an insert of key zero
        logic walk_done;  // current level ends the walk
        logic out_free;   // output register can take a result this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/iabst_dp.sv =====
// Datapath of the tree block: node store, walk registers, result and output registers.
`default_nettype none

module iabst_dp
    import iabst_pkg::*;
#(
    parameter int TREE_SLOTS = 8192,
    parameter int KEY_BITS   = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  wire                     i_in_mode,
    input  wire  [KEY_IN_W-1:0]     i_in_key,
    input  wire                     i_out_ready,
    output logic                    o_out_valid,
    output logic [STATUS_W-1:0]     o_out_status,
    output logic [OUT_DATA_W-1:0]   o_out_data
);

    localparam int IW    = $clog2(TREE_SLOTS);
    localparam int CW    = IW + 1;
    localparam logic [CW-1:0] SLOTS_C  = CW'(TREE_SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(TREE_SLOTS - 1);
    localparam logic [IW-1:0] ROOT_IDX = IW'(1);

    logic [KEY_BITS-1:0] mem [TREE_SLOTS];

    logic [KEY_BITS-1:0] r_rd_data;
    logic [KEY_BITS-1:0] r_key;
    logic                r_mode;
    logic [IW-1:0]       r_idx,    n_idx;
    logic [PROBE_W-1:0]  r_probes, n_probes;
    logic [IW-1:0]       r_clr_idx;

    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_res_found,  n_res_found;
    logic [POS_W-1:0]    r_res_pos,    n_res_pos;
    logic [PROBE_W-1:0]  r_res_probes, n_res_probes;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_found;
    logic [POS_W-1:0]    r_out_pos;
    logic [PROBE_W-1:0]  r_out_probes;

    logic [KEY_BITS-1:0] in_key_m;
    logic                here_empty;
    logic                here_hit;
    logic                go_left;
    logic [CW-1:0]       child;
    logic                child_out;
    logic                walk_done;
    logic [IW-1:0]       rd_addr;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;
    logic [PROBE_W-1:0]  probes_inc;

    assign in_key_m   = KEY_BITS'(i_in_key);
    assign here_empty = (r_rd_data == '0);
    assign here_hit   = (r_rd_data == r_key);
    assign go_left    = (r_key < r_rd_data);
    assign child      = {r_idx, ~go_left};
    assign child_out  = (child >= SLOTS_C);
    assign walk_done  = here_empty | here_hit | child_out;
    assign probes_inc = r_probes + PROBE_W'(1);

    assign o_sts.clr_last  = (r_clr_idx == LAST_IDX);
    assign o_sts.in_zero   = (i_in_mode == MODE_INSERT) && (in_key_m == '0);
    assign o_sts.walk_done = walk_done;
    assign o_sts.out_free  = ~r_out_valid | i_out_ready;

    // The read address follows the walk so that the next level's slot is read while the current level is evaluated.
    always_comb begin
        if (i_cmd.accept) begin
            rd_addr = ROOT_IDX;
        end else if (i_cmd.walk && !walk_done) begin
            rd_addr = child[IW-1:0];
        end else begin
            rd_addr = r_idx;
        end
    end

    assign wr_en   = i_cmd.clear | (i_cmd.walk & (r_mode == MODE_INSERT) & here_empty);
    assign wr_addr = i_cmd.clear ? r_clr_idx : r_idx;
    assign wr_data = i_cmd.clear ? '0 : r_key;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        n_idx        = r_idx;
        n_probes     = r_probes;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_pos    = r_res_pos;
        n_res_probes = r_res_probes;
        if (i_cmd.accept) begin
            n_idx        = ROOT_IDX;
            n_probes     = '0;
            n_res_status = STS_ZERO;
            n_res_found  = 1'b0;
            n_res_pos    = '0;
            n_res_probes = '0;
        end else if (i_cmd.walk) begin
            if (!walk_done) begin
                n_idx = child[IW-1:0];
                if (r_mode == MODE_SEARCH) begin
                    n_probes = probes_inc;
                end
            end else if (r_mode == MODE_INSERT) begin
                n_res_found  = 1'b0;
                n_res_probes = '0;
                priority if (here_empty) begin
                    n_res_status = STS_STORED;
                    n_res_pos    = POS_W'(r_idx);
                end else if (here_hit) begin
                    n_res_status = STS_DUP;
                    n_res_pos    = POS_W'(r_idx);
                end else begin
                    n_res_status = STS_NOROOM;
                    n_res_pos    = '0;
                end
            end else begin
                n_res_status = STS_SEARCH;
                priority if (here_empty) begin
                    n_res_found  = 1'b0;
                    n_res_pos    = '0;
                    n_res_probes = r_probes;
                end else if (here_hit) begin
                    n_res_found  = 1'b1;
                    n_res_pos    = POS_W'(r_idx);
                    n_res_probes = probes_inc;
                end else begin
                    n_res_found  = 1'b0;
                    n_res_pos    = '0;
                    n_res_probes = probes_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_in_mode;
            r_key  <= in_key_m;
        end
        r_idx        <= n_idx;
        r_probes     <= n_probes;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_pos    <= n_res_pos;
        r_res_probes <= n_res_probes;
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_pos    <= r_res_pos;
            r_out_probes <= r_res_probes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_clr_idx <= r_clr_idx + IW'(1);
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = {{(OUT_DATA_W - 1 - POS_W - PROBE_W){1'b0}},
                           r_out_probes, r_out_pos, r_out_found};

endmodule

`default_nettype wire

// ===== design/iabst_ctrl.sv =====
// Controller state machine of the tree block: clearing pass, accept, walk and hand-off.
`default_nettype none

module iabst_ctrl
    import iabst_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_req_valid,
    output logic     o_req_ready,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign accept      = i_req_valid & o_req_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.accept = accept;
                if (accept) begin
                    // An insert of key zero needs no walk.
                    n_state = i_sts.in_zero ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/implicit_array_bst_insert_search.sv =====
// Top level of the implicit-array binary search tree with insert and search.
//
// Requests enter on the s_axis channel: tuser selects insert (0) or search (1)
// and tdata carries the key. One result per request leaves on m_axis: tuser is
// the status and tdata holds found, position and probe count.
// The tree lives in one memory of TREE_SLOTS entries, with one write port and
// one read port, root at slot 1. After reset a clearing pass writes zero to
// every slot, one slot a cycle, and the block takes no request until the pass
// has ended. A request walks one tree level per cycle, limited by the single
// memory read port with registered read data. A walk visits 1 to
// clog2(TREE_SLOTS) levels; its result is then registered, moved to the output
// register and made valid, and only after that hand-off is the next request
// taken. An insert of key zero skips the walk.
// Results wait in an output register; while the receiver stalls, a finished
// walk holds its result and the block takes no new request until that
// register frees.
`default_nettype none

module implicit_array_bst_insert_search
    import iabst_pkg::*;
#(
    parameter int TREE_SLOTS = 8192,
    parameter int KEY_BITS   = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [KEY_IN_W-1:0]    s_axis_tdata,   // [15:0] key
    input  wire                    s_axis_tuser,   // [0] mode
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [0] found, [13:1] position,
                                                    // [17:14] probe_count, [23:18] zero
    output logic [STATUS_W-1:0]    m_axis_tuser    // [2:0] status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    iabst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    iabst_dp #(
        .TREE_SLOTS (TREE_SLOTS),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_mode    (s_axis_tuser),
        .i_in_key     (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== dv/bst_result_checker.sv =====
// Checker for the binary search tree block: shadows the tree, predicts each result and compares.
module bst_result_checker
    import iabst_pkg::*;
#(
    parameter int TREE_SLOTS = 8192
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_req_valid,
    input  wire                    i_req_ready,
    input  wire  [KEY_IN_W-1:0]    i_req_data,    // [15:0] key
    input  wire                    i_req_user,    // [0] mode
    input  wire                    i_res_valid,
    input  wire                    i_res_ready,
    input  wire  [OUT_DATA_W-1:0]  i_res_data,    // [0] found, [13:1] position,
                                                  // [17:14] probe_count, [23:18] zero
    input  wire  [STATUS_W-1:0]    i_res_user,    // [2:0] status
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    position;
        logic [PROBE_W-1:0]  probes;
    } t_bst_result;

    logic [KEY_IN_W-1:0] shadow_tree [TREE_SLOTS];
    t_bst_result         expected_results [$];
    int                  fail_count = 0;

    // Walks the shadow tree for one request, updating it on a successful insert.
    function automatic t_bst_result walk_tree(input logic mode, input logic [KEY_IN_W-1:0] key);
        t_bst_result         res;
        int                  slot;
        logic [KEY_IN_W-1:0] here;
        res  = '0;
        slot = 1;
        if (mode == MODE_INSERT) begin
            res.status = STS_NOROOM;
            if (key == '0) begin
                res.status = STS_ZERO;
            end else begin
                while (slot < TREE_SLOTS) begin
                    here = shadow_tree[slot];
                    if (here == '0) begin
                        shadow_tree[slot] = key;
                        res.status   = STS_STORED;
                        res.position = POS_W'(slot);
                        break;
                    end
                    if (here == key) begin
                        res.status   = STS_DUP;
                        res.position = POS_W'(slot);
                        break;
                    end
                    slot = (key < here) ? 2 * slot : 2 * slot + 1;
                end
            end
        end else begin
            res.status = STS_SEARCH;
            while (slot < TREE_SLOTS && shadow_tree[slot] != '0) begin
                here       = shadow_tree[slot];
                res.probes = res.probes + 1'b1;
                if (here == key) begin
                    res.found    = 1'b1;
                    res.position = POS_W'(slot);
                    break;
                end
                slot = (key < here) ? 2 * slot : 2 * slot + 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_bst_result got;
        t_bst_result want;
        logic        bad;
        if (!i_rst_n) begin
            expected_results.delete();
            for (int slot = 0; slot < TREE_SLOTS; slot++) shadow_tree[slot] = '0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got.status   = i_res_user;
                got.found    = i_res_data[0];
                got.position = i_res_data[POS_W:1];
                got.probes   = i_res_data[POS_W+PROBE_W:POS_W+1];
                if (expected_results.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("[%0t] unexpected result: status %0d found %0d position %0d probes %0d",
                                 $realtime, got.status, got.found, got.position, got.probes);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    bad  = 1'b0;
                    if (got.status !== want.status) bad = 1'b1;
                    if (got.found !== want.found) bad = 1'b1;
                    if (got.position !== want.position) bad = 1'b1;
                    if (got.probes !== want.probes) bad = 1'b1;
                    if (bad) begin
                        if (fail_count < MAX_REPORTS) begin
                            $write("[%0t] mismatch: expected status %0d found %0d",
                                   $realtime, want.status, want.found);
                            $write(" position %0d probes %0d,", want.position, want.probes);
                            $display(" got status %0d found %0d position %0d probes %0d",
                                     got.status, got.found, got.position, got.probes);
                        end
                        fail_count++;
                    end
                end
            end
            // The request's result cannot leave in the cycle it is taken, so it is queued last.
            if (i_req_valid && i_req_ready)
                expected_results.push_back(walk_tree(i_req_user, i_req_data));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the binary search tree block: reset, stimulus, flow control and verdict.
module tb_top;
    import iabst_pkg::*;

    localparam int TREE_SLOTS        = 8192;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int DRAIN_CYCLES      = 40;
    localparam int RESET_CYCLES      = 12;
    localparam int ITEMS_PER_PHASE   = 150;
    localparam int SEND_IDLE_PCT [4] = '{0, 77, 0, 20};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 77, 20};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [KEY_IN_W-1:0]   s_axis_tdata  = '0;    // [15:0] key
    logic                  s_axis_tuser  = 1'b0;  // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // [0] found, [13:1] position,
                                                  // [17:14] probe_count, [23:18] zero
    logic [STATUS_W-1:0]   m_axis_tuser;          // [2:0] status

    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    cycle_count    = 0;
    int                    checker_fails;
    int                    results_pending;
    logic [KEY_IN_W-1:0]   planted_keys [$];

    always #5 i_clk = ~i_clk;

    implicit_array_bst_insert_search #(
        .TREE_SLOTS (TREE_SLOTS),
        .KEY_BITS   (KEY_IN_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bst_result_checker #(
        .TREE_SLOTS (TREE_SLOTS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .o_fail_count (checker_fails),
        .o_pending    (results_pending)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The clearing pass after reset is included in the limit, which is several times the
    // slowest plausible run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is taken; tvalid stays high so that
    // a following request can go out without a gap.
    task automatic send_request(input logic mode, input logic [KEY_IN_W-1:0] key);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [KEY_IN_W-1:0] pick_planted_key();
        return planted_keys[$urandom_range(planted_keys.size() - 1)];
    endfunction

    initial begin
        logic [KEY_IN_W-1:0] key;
        logic [KEY_IN_W-1:0] step;
        logic                mode;
        int                  sel;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty tree: a search makes no probes, and key zero is refused.
        send_request(MODE_SEARCH, 16'hFFFF);
        send_request(MODE_INSERT, 16'h0000);

        // A bisecting path reaches the deepest level while leaving the siblings free; the
        // fourteenth key would need a slot beyond the store and is dropped.
        key  = 16'h8000;
        step = 16'h4000;
        for (int level = 1; level <= 14; level++) begin
            send_request(MODE_INSERT, key);
            planted_keys.push_back(key);
            key  = (level % 2 == 1) ? key - step : key + step;
            step = step >> 1;
        end

        send_request(MODE_INSERT, 16'hFFFF);
        send_request(MODE_INSERT, 16'h0001);
        send_request(MODE_INSERT, 16'hFFFF);
        planted_keys.push_back(16'hFFFF);
        planted_keys.push_back(16'h0001);
        send_request(MODE_SEARCH, 16'h0000);
        send_request(MODE_SEARCH, 16'h5558);
        send_request(MODE_SEARCH, 16'h5554);
        send_request(MODE_SEARCH, 16'hFFFF);
        send_request(MODE_SEARCH, 16'h0001);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                sel = $urandom_range(99);
                if ($urandom_range(99) < 45) begin
                    mode = MODE_INSERT;
                    if (sel < 3)       key = '0;
                    else if (sel < 13) key = pick_planted_key();
                    else if (sel < 35) key = KEY_IN_W'($urandom_range(63, 1));
                    else               key = KEY_IN_W'($urandom);
                    if (key != '0) planted_keys.push_back(key);
                end else begin
                    // Most searches look for keys already offered, so that hits are common.
                    mode = MODE_SEARCH;
                    if (sel < 5)       key = '0;
                    else if (sel < 60) key = pick_planted_key();
                    else if (sel < 75) key = KEY_IN_W'($urandom_range(63, 1));
                    else               key = KEY_IN_W'($urandom);
                end
                send_request(mode, key);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (checker_fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
